@@ rtl/oamm_pkg.sv @@
// shared constants, weights and types for the obstacle avoidance mode mixer
package oamm_pkg;

   // field widths
   localparam int PROX_W   = 12;
   localparam int NUM_PROX = 8;
   localparam int SPD_W    = 15;
   localparam int THR_W    = 12;
   localparam int OFF_W    = 11;
   localparam int CSR_W    = 12;
   localparam int CSR_AW   = 3;

   // packed channel widths
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 32;

   // braitenberg arithmetic
   localparam int SUM_W     = 21;
   localparam int MAG_W     = 20;
   localparam int Q_W       = 11;
   localparam int BR_W      = 13;
   localparam int PROD_W    = 40;
   localparam int SCALE_DIV = 350;
   localparam int RECIP_SH  = 28;
   // floor of 2^28 / 350, estimate is never above the true quotient
   localparam int RECIP     = (1 << RECIP_SH) / SCALE_DIV;

   // internal width of the rescale rule
   localparam int RS_W = 18;

   // right sum uses entries 0..7, left sum uses entries 8..15
   localparam logic signed [7:0] WEIGHTS [16] = '{
      8'sd17, 8'sd29, 8'sd34, 8'sd10, 8'sd8, -8'sd38, -8'sd56, -8'sd76,
      -8'sd72, -8'sd58, -8'sd36, 8'sd8, 8'sd10, 8'sd36, 8'sd28, 8'sd18
   };

   // register reset values
   localparam logic [THR_W-1:0]        ENTER_RST = 12'd1800;
   localparam logic [THR_W-1:0]        EXIT_RST  = 12'd70;
   localparam logic [THR_W-1:0]        LIMIT_RST = 12'd800;
   localparam logic signed [OFF_W-1:0] LOFF_RST  = 11'sd66;
   localparam logic signed [OFF_W-1:0] ROFF_RST  = 11'sd72;

   typedef enum logic [CSR_AW-1:0] {
      CSR_ENTER = 3'd0,
      CSR_EXIT  = 3'd1,
      CSR_LIMIT = 3'd2,
      CSR_LOFF  = 3'd3,
      CSR_ROFF  = 3'd4
   } csr_index_type;

endpackage

@@ rtl/obstacle_avoid_mode_mixer.sv @@
// top level of the obstacle avoidance mode mixer, five-stage pipeline
//
// one request transfer per control tick carries eight proximity readings and the
// formation controller's wheel pair; one response transfer comes back per request
// with the limited wheel speeds and the mode that was used. the pipeline takes a
// new request every cycle unless the output holds, and each request passes through
// the input register, weighted sums, reciprocal multiply, quotient correction and
// offset, then mode select and rescale into the output register. while a response
// waits for rsp_tready the whole pipeline holds, so req_tready follows the output
// side. the avoidance flag is entered when a front sensor (0, 1, 6 or 7) is above
// enter_threshold and left after the response once every reading is below
// exit_threshold. registers are written on csr_we and should only be changed while
// no request is in flight.
module obstacle_avoid_mode_mixer (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // prox0..prox7 (12 bits each), form_left (15), form_right (15), zero pad
   input  logic [oamm_pkg::REQ_DATA_W-1:0]    req_tdata,
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // left_speed (15), right_speed (15), zero pad
   output logic [oamm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // avoiding
   output logic                               rsp_tuser,
   // register write port
   input  logic                               csr_we,
   input  logic [oamm_pkg::CSR_AW-1:0]        csr_addr,
   input  logic [oamm_pkg::CSR_W-1:0]         csr_wdata
);

   // configuration registers
   logic        [oamm_pkg::THR_W-1:0] enter_thr_ff;
   logic        [oamm_pkg::THR_W-1:0] exit_thr_ff;
   logic        [oamm_pkg::THR_W-1:0] limit_ff;
   logic signed [oamm_pkg::OFF_W-1:0] loff_ff;
   logic signed [oamm_pkg::OFF_W-1:0] roff_ff;

   // pipeline advances whenever the output register is free or being drained
   logic advance;

   // stage 1: captured request
   logic                              s1_valid_ff;
   logic        [oamm_pkg::PROX_W-1:0] s1_prox_ff [oamm_pkg::NUM_PROX];
   logic signed [oamm_pkg::SPD_W-1:0]  s1_fl_ff;
   logic signed [oamm_pkg::SPD_W-1:0]  s1_fr_ff;

   // stage 2: weighted sums, max reading, front check
   logic                               s2_valid_ff;
   logic signed [oamm_pkg::SUM_W-1:0]  s2_sum_ff [2];
   logic        [oamm_pkg::PROX_W-1:0] s2_max_ff;
   logic                               s2_front_ff;
   logic signed [oamm_pkg::SPD_W-1:0]  s2_fl_ff;
   logic signed [oamm_pkg::SPD_W-1:0]  s2_fr_ff;
   logic signed [oamm_pkg::SUM_W-1:0]  sum_in [2];
   logic        [oamm_pkg::PROX_W-1:0] max_in;
   logic                               front_in;

   // stage 3: magnitude and quotient estimate
   logic                               s3_valid_ff;
   logic        [oamm_pkg::MAG_W-1:0]  s3_mag_ff [2];
   logic                               s3_neg_ff [2];
   logic        [oamm_pkg::Q_W-1:0]    s3_q0_ff  [2];
   logic                               s3_front_ff;
   logic                               s3_below_ff;
   logic signed [oamm_pkg::SPD_W-1:0]  s3_fl_ff;
   logic signed [oamm_pkg::SPD_W-1:0]  s3_fr_ff;
   logic        [oamm_pkg::MAG_W-1:0]  mag_in [2];
   logic        [oamm_pkg::PROD_W-1:0] prod_in [2];
   logic        [oamm_pkg::Q_W-1:0]    q0_in [2];

   // stage 4: corrected quotient plus offset
   logic                               s4_valid_ff;
   logic signed [oamm_pkg::BR_W-1:0]   s4_br_ff [2];
   logic                               s4_front_ff;
   logic                               s4_below_ff;
   logic signed [oamm_pkg::SPD_W-1:0]  s4_fl_ff;
   logic signed [oamm_pkg::SPD_W-1:0]  s4_fr_ff;
   logic        [oamm_pkg::MAG_W-1:0]  rem_in [2];
   logic        [oamm_pkg::Q_W-1:0]    q_in [2];
   logic signed [oamm_pkg::BR_W-1:0]   br_in [2];
   logic signed [oamm_pkg::BR_W-1:0]   off_ext [2];

   // stage 5: mode, selection, rescale
   logic                               mode_ff;
   logic                               mode_in;
   logic                               mode_used;
   logic signed [oamm_pkg::SPD_W-1:0]  sel_l;
   logic signed [oamm_pkg::SPD_W-1:0]  sel_r;
   logic signed [oamm_pkg::SPD_W-1:0]  lim_l;
   logic signed [oamm_pkg::SPD_W-1:0]  lim_r;

   // output register
   logic                               out_valid_ff;
   logic signed [oamm_pkg::SPD_W-1:0]  out_l_ff;
   logic signed [oamm_pkg::SPD_W-1:0]  out_r_ff;
   logic                               out_avoid_ff;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enter_thr_ff <= oamm_pkg::ENTER_RST;
         exit_thr_ff  <= oamm_pkg::EXIT_RST;
         limit_ff     <= oamm_pkg::LIMIT_RST;
         loff_ff      <= oamm_pkg::LOFF_RST;
         roff_ff      <= oamm_pkg::ROFF_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            oamm_pkg::CSR_ENTER: enter_thr_ff <= csr_wdata;
            oamm_pkg::CSR_EXIT:  exit_thr_ff  <= csr_wdata;
            oamm_pkg::CSR_LIMIT: limit_ff     <= csr_wdata;
            oamm_pkg::CSR_LOFF:  loff_ff      <= $signed(csr_wdata[oamm_pkg::OFF_W-1:0]);
            oamm_pkg::CSR_ROFF:  roff_ff      <= $signed(csr_wdata[oamm_pkg::OFF_W-1:0]);
            default: begin
               // writes beyond the register list are dropped
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_tvalid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         out_valid_ff <= s4_valid_ff;
         if (s4_valid_ff) begin
            mode_ff <= mode_in;
         end
      end
   end

   // ---------------------------------------------------------------- stage 2 logic
   always_comb begin
      sum_in[0] = '0;
      sum_in[1] = '0;
      max_in    = '0;
      for (int i = 0; i < oamm_pkg::NUM_PROX; i++) begin
         sum_in[1] = sum_in[1] + oamm_pkg::SUM_W'(oamm_pkg::WEIGHTS[i])
                   * $signed(oamm_pkg::SUM_W'(s1_prox_ff[i]));
         sum_in[0] = sum_in[0] + oamm_pkg::SUM_W'(oamm_pkg::WEIGHTS[i + oamm_pkg::NUM_PROX])
                   * $signed(oamm_pkg::SUM_W'(s1_prox_ff[i]));
         if (s1_prox_ff[i] > max_in) begin
            max_in = s1_prox_ff[i];
         end
      end
      // front sensors sit at both ends of the ring
      front_in = (s1_prox_ff[0] > enter_thr_ff) || (s1_prox_ff[1] > enter_thr_ff)
              || (s1_prox_ff[6] > enter_thr_ff) || (s1_prox_ff[7] > enter_thr_ff);
   end

   // ---------------------------------------------------------------- stage 3 logic
   // index 0 is the left side, 1 the right side
   always_comb begin
      for (int s = 0; s < 2; s++) begin
         mag_in[s]  = s2_sum_ff[s][oamm_pkg::SUM_W-1]
                    ? oamm_pkg::MAG_W'(-s2_sum_ff[s])
                    : oamm_pkg::MAG_W'(s2_sum_ff[s]);
         prod_in[s] = oamm_pkg::PROD_W'(mag_in[s]) * oamm_pkg::PROD_W'(oamm_pkg::RECIP);
         q0_in[s]   = prod_in[s][oamm_pkg::RECIP_SH +: oamm_pkg::Q_W];
      end
   end

   // ---------------------------------------------------------------- stage 4 logic
   assign off_ext[0] = oamm_pkg::BR_W'(loff_ff);
   assign off_ext[1] = oamm_pkg::BR_W'(roff_ff);

   always_comb begin
      for (int s = 0; s < 2; s++) begin
         // estimate is low by at most one, fix it with one compare
         rem_in[s] = s3_mag_ff[s]
                   - oamm_pkg::MAG_W'(oamm_pkg::MAG_W'(s3_q0_ff[s])
                                    * oamm_pkg::MAG_W'(oamm_pkg::SCALE_DIV));
         q_in[s]   = (rem_in[s] >= oamm_pkg::MAG_W'(oamm_pkg::SCALE_DIV))
                   ? s3_q0_ff[s] + oamm_pkg::Q_W'(1) : s3_q0_ff[s];
         // truncation toward zero: negate the magnitude quotient
         br_in[s]  = (s3_neg_ff[s] ? -$signed(oamm_pkg::BR_W'(q_in[s]))
                                   :  $signed(oamm_pkg::BR_W'(q_in[s])))
                   + off_ext[s];
      end
   end

   // ---------------------------------------------------------------- stage 5 logic
   always_comb begin
      mode_used = mode_ff || s4_front_ff;
      mode_in   = mode_used && !s4_below_ff;
      if (mode_used) begin
         sel_l = oamm_pkg::SPD_W'(s4_br_ff[0]);
         sel_r = oamm_pkg::SPD_W'(s4_br_ff[1]);
      end else begin
         sel_l = s4_fl_ff;
         sel_r = s4_fr_ff;
      end
   end

   oamm_rescale u_rescale (
      .x_i   (sel_l),
      .y_i   (sel_r),
      .lim_i (limit_ff),
      .x_o   (lim_l),
      .y_o   (lim_r)
   );

   // ---------------------------------------------------------------- payload
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < oamm_pkg::NUM_PROX; i++) begin
            s1_prox_ff[i] <= req_tdata[i*oamm_pkg::PROX_W +: oamm_pkg::PROX_W];
         end
         s1_fl_ff <= $signed(req_tdata[oamm_pkg::NUM_PROX*oamm_pkg::PROX_W +: oamm_pkg::SPD_W]);
         s1_fr_ff <= $signed(req_tdata[oamm_pkg::NUM_PROX*oamm_pkg::PROX_W + oamm_pkg::SPD_W
                                       +: oamm_pkg::SPD_W]);

         s2_sum_ff   <= sum_in;
         s2_max_ff   <= max_in;
         s2_front_ff <= front_in;
         s2_fl_ff    <= s1_fl_ff;
         s2_fr_ff    <= s1_fr_ff;

         for (int s = 0; s < 2; s++) begin
            s3_mag_ff[s] <= mag_in[s];
            s3_neg_ff[s] <= s2_sum_ff[s][oamm_pkg::SUM_W-1];
            s3_q0_ff[s]  <= q0_in[s];
         end
         s3_front_ff <= s2_front_ff;
         s3_below_ff <= s2_max_ff < exit_thr_ff;
         s3_fl_ff    <= s2_fl_ff;
         s3_fr_ff    <= s2_fr_ff;

         s4_br_ff    <= br_in;
         s4_front_ff <= s3_front_ff;
         s4_below_ff <= s3_below_ff;
         s4_fl_ff    <= s3_fl_ff;
         s4_fr_ff    <= s3_fr_ff;

         out_l_ff     <= lim_l;
         out_r_ff     <= lim_r;
         out_avoid_ff <= mode_used;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(oamm_pkg::RSP_DATA_W - 2*oamm_pkg::SPD_W){1'b0}}, out_r_ff, out_l_ff};
   assign rsp_tuser  = out_avoid_ff;

   // ---------------------------------------------------------------- checks
   // reciprocal estimate must be within one of the true quotient
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (rem_in[0] < oamm_pkg::MAG_W'(2*oamm_pkg::SCALE_DIV))
                   && (rem_in[1] < oamm_pkg::MAG_W'(2*oamm_pkg::SCALE_DIV)))
      else $error("quotient estimate off by more than one");

   // avoidance is only entered by a front sensor transfer
   a_mode_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(mode_ff) |-> $past(s4_valid_ff && advance && s4_front_ff))
      else $error("avoidance entered without a front reading");

   // avoidance is only left after an item with all readings below exit level
   a_mode_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(mode_ff) |-> $past(reset) || $past(s4_valid_ff && advance && s4_below_ff))
      else $error("avoidance left without a low reading");

   // formation items without a front hit report formation mode
   a_flag_formation: assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && advance && !mode_ff && !s4_front_ff) |=> !rsp_tuser)
      else $error("avoiding flag set on a formation item");

endmodule

@@ rtl/oamm_rescale.sv @@
// limit-and-rescale rule that keeps the wheel difference unless both clip oppositely
module oamm_rescale (
   input  logic signed [oamm_pkg::SPD_W-1:0] x_i,
   input  logic signed [oamm_pkg::SPD_W-1:0] y_i,
   input  logic        [oamm_pkg::THR_W-1:0] lim_i,
   output logic signed [oamm_pkg::SPD_W-1:0] x_o,
   output logic signed [oamm_pkg::SPD_W-1:0] y_o
);

   logic signed [oamm_pkg::RS_W-1:0] x;
   logic signed [oamm_pkg::RS_W-1:0] y;
   logic signed [oamm_pkg::RS_W-1:0] d;
   logic signed [oamm_pkg::RS_W-1:0] l;
   logic signed [oamm_pkg::RS_W-1:0] nl;

   always_comb begin
      x  = oamm_pkg::RS_W'(x_i);
      y  = oamm_pkg::RS_W'(y_i);
      l  = $signed(oamm_pkg::RS_W'(lim_i));
      nl = -l;
      d  = '0;
      if (x > 0 && y > 0) begin
         if (x > y) begin
            d = x - y;
            if (x > l) begin
               x = l;
               y = l - d;
            end
         end else begin
            d = y - x;
            if (y > l) begin
               y = l;
               x = l - d;
            end
         end
      end else if (x > 0 && y < 0) begin
         d = x - y;
         if (x >= l && y <= nl) begin
            x = l;
            y = nl;
         end else if (x >= l) begin
            x = l;
            y = l - d;
         end else if (y <= nl) begin
            x = nl + d;
            y = nl;
         end
      end else if (x < 0 && y > 0) begin
         d = y - x;
         if (x <= nl && y >= l) begin
            x = nl;
            y = l;
         end else if (y >= l) begin
            x = l - d;
            y = l;
         end else if (x <= nl) begin
            x = nl;
            y = nl + d;
         end
      end else if (x < 0 && y < 0) begin
         if (x < y) begin
            d = y - x;
            if (x < nl) begin
               x = nl;
               y = nl + d;
            end
         end else begin
            d = x - y;
            if (y < nl) begin
               x = nl + d;
               y = nl;
            end
         end
      end
      // a zero on either wheel leaves both untouched
   end

   assign x_o = x[oamm_pkg::SPD_W-1:0];
   assign y_o = y[oamm_pkg::SPD_W-1:0];

endmodule
